/* rtl/papt_pkg.sv */
`default_nettype none
package papt_pkg;

  // fixed field widths
  localparam int unsigned COORD_WIDTH = 16;
  localparam int unsigned COEF_WIDTH = 32;
  localparam int unsigned COEF_FRAC_BITS = 16;
  localparam int unsigned RES_WIDTH = 32;
  localparam int unsigned CFG_DATA_WIDTH = 64;
  localparam int unsigned CFG_IDX_WIDTH = 3;

  // datapath widths
  localparam int unsigned PROD_W = COEF_WIDTH + COORD_WIDTH;
  localparam int unsigned SUM_W = PROD_W + 2;
  localparam int unsigned QUO_W = RES_WIDTH + 1;

  // register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MODE = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_PAIR_A = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_PAIR_B = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_PAIR_C = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_PAIR_D = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_M22 = 3'd5;

  // register reset values
  localparam logic [CFG_DATA_WIDTH-1:0] RST_PAIR_A = 64'd65536;
  localparam logic [CFG_DATA_WIDTH-1:0] RST_PAIR_B = 64'd0;
  localparam logic [CFG_DATA_WIDTH-1:0] RST_PAIR_C = 64'd65536;
  localparam logic [CFG_DATA_WIDTH-1:0] RST_PAIR_D = 64'd0;
  localparam logic [COEF_WIDTH-1:0] RST_M22 = 32'd65536;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x_in;
    logic signed [COORD_WIDTH-1:0] y_in;
  } in_req_t;

  typedef struct packed {
    logic signed [RES_WIDTH-1:0] x_out;
    logic signed [RES_WIDTH-1:0] y_out;
    logic divide_by_zero;
  } out_req_t;

  // matrix coefficients
  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] m00;
    logic signed [COEF_WIDTH-1:0] m01;
    logic signed [COEF_WIDTH-1:0] m02;
    logic signed [COEF_WIDTH-1:0] m10;
    logic signed [COEF_WIDTH-1:0] m11;
    logic signed [COEF_WIDTH-1:0] m12;
    logic signed [COEF_WIDTH-1:0] m20;
    logic signed [COEF_WIDTH-1:0] m21;
    logic signed [COEF_WIDTH-1:0] m22;
  } coef_t;

  // state handed from cell to cell of the divider chain
  typedef struct packed {
    logic valid;
    logic persp;
    logic dz;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
    logic [SUM_W-1:0] rem_x;
    logic [SUM_W-1:0] rem_y;
    logic [SUM_W-1:0] den;
    logic [QUO_W-1:0] quo_x;
    logic [QUO_W-1:0] quo_y;
    logic signed [RES_WIDTH-1:0] aff_x;
    logic signed [RES_WIDTH-1:0] aff_y;
  } dvc_t;

  // clamp a sign and magnitude to a signed 32 bit result
  function automatic logic signed [RES_WIDTH-1:0] sat32(input logic neg,
                                                       input logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] max_pos;
    logic [RES_WIDTH-1:0] low;
    max_pos = SUM_W'({1'b0, {(RES_WIDTH-1){1'b1}}});
    low = v[RES_WIDTH-1:0];
    if (!neg) begin
      sat32 = (v > max_pos) ? {1'b0, {(RES_WIDTH-1){1'b1}}} : low;
    end else begin
      sat32 = (v > max_pos + SUM_W'(1)) ? {1'b1, {(RES_WIDTH-1){1'b0}}} : (~low + 1'b1);
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/papt_front.sv */
`default_nettype none
module papt_front #(
  parameter int unsigned FRAC_BITS = papt_pkg::COEF_FRAC_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_take,
  input  wire papt_pkg::in_req_t in_data,
  input  wire papt_pkg::coef_t  coef,
  input  wire logic             persp,
  output papt_pkg::dvc_t        cell_out
);

  localparam int unsigned PW = papt_pkg::PROD_W;
  localparam int unsigned SW = papt_pkg::SUM_W;
  localparam int unsigned QW = papt_pkg::QUO_W;

  logic s1_valid_r;
  logic signed [PW-1:0] p00_r, p01_r, p10_r, p11_r, p20_r, p21_r;
  papt_pkg::dvc_t s2_r, s2_nxt;

  logic signed [SW-1:0] sum_x, sum_y, sum_z;
  logic [SW-1:0] mag_x, mag_y, mag_z;
  logic neg_z;

  // multiply stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r <= PW'(coef.m00) * PW'(in_data.x_in);
      p01_r <= PW'(coef.m01) * PW'(in_data.y_in);
      p10_r <= PW'(coef.m10) * PW'(in_data.x_in);
      p11_r <= PW'(coef.m11) * PW'(in_data.y_in);
      p20_r <= PW'(coef.m20) * PW'(in_data.x_in);
      p21_r <= PW'(coef.m21) * PW'(in_data.y_in);
    end
  end

  // row sums as sign and magnitude
  always_comb begin
    sum_x = SW'(p00_r) + SW'(p01_r) + SW'(coef.m02);
    sum_y = SW'(p10_r) + SW'(p11_r) + SW'(coef.m12);
    sum_z = SW'(p20_r) + SW'(p21_r) + SW'(coef.m22);
    mag_x = sum_x[SW-1] ? SW'(-sum_x) : SW'(sum_x);
    mag_y = sum_y[SW-1] ? SW'(-sum_y) : SW'(sum_y);
    mag_z = sum_z[SW-1] ? SW'(-sum_z) : SW'(sum_z);
    neg_z = sum_z[SW-1];

    s2_nxt.valid = s1_valid_r;
    s2_nxt.persp = persp;
    s2_nxt.dz = (mag_z == '0);
    s2_nxt.neg_x = sum_x[SW-1] ^ neg_z;
    s2_nxt.neg_y = sum_y[SW-1] ^ neg_z;
    // quotient would need more than QW bits
    s2_nxt.ovf_x = (mag_x >> QW) >= mag_z;
    s2_nxt.ovf_y = (mag_y >> QW) >= mag_z;
    s2_nxt.rem_x = mag_x;
    s2_nxt.rem_y = mag_y;
    s2_nxt.den = mag_z;
    s2_nxt.quo_x = '0;
    s2_nxt.quo_y = '0;
    s2_nxt.aff_x = papt_pkg::sat32(sum_x[SW-1], mag_x >> FRAC_BITS);
    s2_nxt.aff_y = papt_pkg::sat32(sum_y[SW-1], mag_y >> FRAC_BITS);
  end

  // sum stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r <= '0;
    end else if (en) begin
      s2_r <= s2_nxt;
    end
  end

  assign cell_out = s2_r;

endmodule
`default_nettype wire

/* rtl/papt_cell.sv */
`default_nettype none
module papt_cell #(
  parameter int unsigned BIT = 0
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire papt_pkg::dvc_t cell_in,
  output papt_pkg::dvc_t      cell_out
);

  localparam int unsigned SW = papt_pkg::SUM_W;
  localparam int unsigned WW = SW + papt_pkg::QUO_W;

  papt_pkg::dvc_t cell_r, cell_nxt;
  logic [WW-1:0] trial;
  logic take_x, take_y;

  // one restoring step per quotient bit
  always_comb begin
    trial = WW'(cell_in.den) << BIT;
    take_x = WW'(cell_in.rem_x) >= trial;
    take_y = WW'(cell_in.rem_y) >= trial;
    cell_nxt = cell_in;
    if (take_x) begin
      cell_nxt.rem_x = cell_in.rem_x - SW'(trial);
      cell_nxt.quo_x[BIT] = 1'b1;
    end
    if (take_y) begin
      cell_nxt.rem_y = cell_in.rem_y - SW'(trial);
      cell_nxt.quo_y[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r <= '0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule
`default_nettype wire

/* rtl/point_affine_perspective_transform.sv */
// pipeline: multiply, sum, 33 divider cells and an output register between request
//   accept and result valid
// throughput: one point per cycle; the whole pipe holds while a valid result is stalled at the output
// reset: synchronous active-low rst_n clears all valid bits and loads the identity
//   matrix in affine mode
`default_nettype none
module point_affine_perspective_transform #(
  parameter int unsigned COEF_FRAC_BITS = papt_pkg::COEF_FRAC_BITS
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire papt_pkg::in_req_t                      in_data,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output papt_pkg::out_req_t                          out_data,
  input  wire logic                                   cfg_we,
  input  wire logic [papt_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
  input  wire logic [papt_pkg::CFG_DATA_WIDTH-1:0]    cfg_wdata
);

  localparam int unsigned CW = papt_pkg::COEF_WIDTH;
  localparam int unsigned QW = papt_pkg::QUO_W;
  localparam int unsigned SW = papt_pkg::SUM_W;

  logic mode_r;
  logic [papt_pkg::CFG_DATA_WIDTH-1:0] pair_a_r, pair_b_r, pair_c_r, pair_d_r;
  logic [CW-1:0] m22_r;
  papt_pkg::coef_t coef;

  logic en;
  papt_pkg::dvc_t chain [QW+1];
  logic out_valid_r;
  papt_pkg::out_req_t out_data_r, out_data_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      pair_a_r <= papt_pkg::RST_PAIR_A;
      pair_b_r <= papt_pkg::RST_PAIR_B;
      pair_c_r <= papt_pkg::RST_PAIR_C;
      pair_d_r <= papt_pkg::RST_PAIR_D;
      m22_r <= papt_pkg::RST_M22;
    end else if (cfg_we) begin
      case (cfg_index)
        papt_pkg::REG_MODE:   mode_r <= cfg_wdata[0];
        papt_pkg::REG_PAIR_A: pair_a_r <= cfg_wdata;
        papt_pkg::REG_PAIR_B: pair_b_r <= cfg_wdata;
        papt_pkg::REG_PAIR_C: pair_c_r <= cfg_wdata;
        papt_pkg::REG_PAIR_D: pair_d_r <= cfg_wdata;
        papt_pkg::REG_M22:    m22_r <= cfg_wdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // unpack coefficient pairs
  always_comb begin
    coef.m00 = pair_a_r[CW-1:0];
    coef.m01 = pair_a_r[2*CW-1:CW];
    coef.m02 = pair_b_r[CW-1:0];
    coef.m10 = pair_b_r[2*CW-1:CW];
    coef.m11 = pair_c_r[CW-1:0];
    coef.m12 = pair_c_r[2*CW-1:CW];
    coef.m20 = pair_d_r[CW-1:0];
    coef.m21 = pair_d_r[2*CW-1:CW];
    coef.m22 = m22_r;
  end

  // pipe advances unless a finished result is held
  assign en = !(out_valid_r && out_stall);
  assign in_stall = !en;

  papt_front #(
    .FRAC_BITS(COEF_FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_take  (in_valid),
    .in_data  (in_data),
    .coef     (coef),
    .persp    (mode_r),
    .cell_out (chain[0])
  );

  // divider chain, most significant quotient bit first
  for (genvar i = 0; i < QW; i++) begin : g_cell
    papt_cell #(
      .BIT(QW - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .cell_in  (chain[i]),
      .cell_out (chain[i+1])
    );
  end

  // result select and clamp
  always_comb begin
    if (!chain[QW].persp) begin
      out_data_nxt.x_out = chain[QW].aff_x;
      out_data_nxt.y_out = chain[QW].aff_y;
      out_data_nxt.divide_by_zero = 1'b0;
    end else if (chain[QW].dz) begin
      out_data_nxt.x_out = '0;
      out_data_nxt.y_out = '0;
      out_data_nxt.divide_by_zero = 1'b1;
    end else begin
      out_data_nxt.x_out = papt_pkg::sat32(chain[QW].neg_x,
        chain[QW].ovf_x ? {SW{1'b1}} : SW'(chain[QW].quo_x));
      out_data_nxt.y_out = papt_pkg::sat32(chain[QW].neg_y,
        chain[QW].ovf_y ? {SW{1'b1}} : SW'(chain[QW].quo_y));
      out_data_nxt.divide_by_zero = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain[QW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule
`default_nettype wire

/* verif/papt_checker.sv */
`timescale 1ns / 1ps
module papt_checker
  import papt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  in_req_t                   in_data,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  out_req_t                  out_data,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata,
  output int                        fails,
  output int                        pending
);

  // shadow copy of the matrix registers
  logic                      persp;
  logic [CFG_DATA_WIDTH-1:0] pair_a, pair_b, pair_c, pair_d;
  logic [COEF_WIDTH-1:0]     m22;

  out_req_t expected_points[$];

  // clamp sign and magnitude to 32 bits
  function automatic logic signed [RES_WIDTH-1:0] clamp32(input logic neg,
                                                          input logic [63:0] mag);
    if (!neg) begin
      clamp32 = (mag > 64'h7fff_ffff) ? 32'h7fff_ffff : mag[31:0];
    end else begin
      clamp32 = (mag > 64'h8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
    end
  endfunction

  // map one point through the shadow matrix
  function automatic out_req_t map_point(input in_req_t p);
    logic signed [63:0] x, y, sx, sy, sz;
    logic signed [31:0] c00, c01, c02, c10, c11, c12, c20, c21, c22;
    logic [63:0] mx, my, mz;
    out_req_t r;
    x = p.x_in;
    y = p.y_in;
    c00 = pair_a[31:0];
    c01 = pair_a[63:32];
    c02 = pair_b[31:0];
    c10 = pair_b[63:32];
    c11 = pair_c[31:0];
    c12 = pair_c[63:32];
    c20 = pair_d[31:0];
    c21 = pair_d[63:32];
    c22 = m22;
    sx = c00 * x + c01 * y + c02;
    sy = c10 * x + c11 * y + c12;
    sz = c20 * x + c21 * y + c22;
    mx = (sx < 0) ? -sx : sx;
    my = (sy < 0) ? -sy : sy;
    mz = (sz < 0) ? -sz : sz;
    r.divide_by_zero = 1'b0;
    if (!persp) begin
      r.x_out = clamp32(sx < 0, mx >> COEF_FRAC_BITS);
      r.y_out = clamp32(sy < 0, my >> COEF_FRAC_BITS);
    end else if (mz == 64'd0) begin
      r.x_out = '0;
      r.y_out = '0;
      r.divide_by_zero = 1'b1;
    end else begin
      r.x_out = clamp32((sx < 0) != (sz < 0), mx / mz);
      r.y_out = clamp32((sy < 0) != (sz < 0), my / mz);
    end
    return r;
  endfunction

  assign pending = expected_points.size();

  // track writes, predict on accepted requests, compare on accepted results
  always @(posedge clk) begin
    out_req_t e;
    if (!rst_n) begin
      persp <= 1'b0;
      pair_a <= RST_PAIR_A;
      pair_b <= RST_PAIR_B;
      pair_c <= RST_PAIR_C;
      pair_d <= RST_PAIR_D;
      m22 <= RST_M22;
      expected_points.delete();
      fails <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE: persp <= cfg_wdata[0];
          REG_PAIR_A: pair_a <= cfg_wdata;
          REG_PAIR_B: pair_b <= cfg_wdata;
          REG_PAIR_C: pair_c <= cfg_wdata;
          REG_PAIR_D: pair_d <= cfg_wdata;
          REG_M22: m22 <= cfg_wdata[31:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_points.push_back(map_point(in_data));
      end
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d dz=%0b", $time,
                   out_data.x_out, out_data.y_out, out_data.divide_by_zero);
          fails <= fails + 1;
        end else begin
          e = expected_points.pop_front();
          if (e.x_out !== out_data.x_out || e.y_out !== out_data.y_out ||
              e.divide_by_zero !== out_data.divide_by_zero) begin
            $display("%0t: mismatch expected x=%0d y=%0d dz=%0b actual x=%0d y=%0d dz=%0b",
                     $time, e.x_out, e.y_out, e.divide_by_zero,
                     out_data.x_out, out_data.y_out, out_data.divide_by_zero);
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule

/* verif/tb_point_affine_perspective_transform.sv */
`timescale 1ns / 1ps
module tb_point_affine_perspective_transform;
  import papt_pkg::*;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_UNUSED = 3'd6;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  in_req_t                   in_data;
  logic                      out_valid;
  logic                      out_stall;
  out_req_t                  out_data;
  logic                      cfg_we;
  logic [CFG_IDX_WIDTH-1:0]  cfg_index;
  logic [CFG_DATA_WIDTH-1:0] cfg_wdata;
  int                        fails;
  int                        pending;
  int                        idle_pct;
  int                        stall_pct;
  int                        quiet_cycles;
  int                        sent;
  int                        persp_sets;

  point_affine_perspective_transform DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  papt_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // watchdog on cycles with no accepted request or result
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // one write, then a cycle with the enable low
  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // one request, with an optional gap before it
  task automatic send_point(input logic [15:0] x, input logic [15:0] y);
    logic taken;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data.x_in <= x;
    in_data.y_in <= y;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return 32'd0;
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 15) - 8);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic load_matrix(input logic persp, input logic [31:0] c[9]);
    write_reg(REG_MODE, {63'd0, persp});
    write_reg(REG_PAIR_A, {c[1], c[0]});
    write_reg(REG_PAIR_B, {c[3], c[2]});
    write_reg(REG_PAIR_C, {c[5], c[4]});
    write_reg(REG_PAIR_D, {c[7], c[6]});
    write_reg(REG_M22, {32'd0, c[8]});
  endtask

  task automatic corner_points();
    send_point(16'h7fff, 16'h7fff);
    send_point(16'h8000, 16'h8000);
    send_point(16'h7fff, 16'h8000);
    send_point(16'h8000, 16'h7fff);
    send_point(16'h0000, 16'h0000);
    send_point(16'hffff, 16'h0001);
  endtask

  initial begin
    logic [31:0] c[9];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    quiet_cycles = 0;
    sent = 0;
    persp_sets = 0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity after reset
    corner_points();
    drain();

    // saturating affine plus ignored write to an unused index
    c = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
          32'h8000_0000, 32'd0, 32'd0, 32'd0};
    load_matrix(1'b0, c);
    write_reg(REG_UNUSED, 64'hffff_ffff_ffff_ffff);
    corner_points();
    drain();

    // perspective with zero divisor at x = 0
    c = '{32'h0001_0000, 32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'h0001_0000,
          32'd0, 32'd0};
    load_matrix(1'b1, c);
    corner_points();
    send_point(16'h0000, 16'h1234);
    send_point(16'h0003, 16'h8000);
    drain();

    // random phases under changing matrices and idling patterns
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 5)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        3: begin idle_pct = 37; stall_pct = 37; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      foreach (c[i]) c[i] = pick_coef();
      // small third row makes zero divisors likely
      if (ph % 3 == 2) begin
        c[6] = $urandom_range(0, 2) << 16;
        c[7] = $urandom_range(0, 2) << 16;
        c[8] = 32'd0;
      end
      load_matrix(ph[0], c);
      if (ph[0]) persp_sets++;
      repeat (30) send_point(pick_coord(), pick_coord());
      drain();
    end

    idle_pct = 0;
    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d points over %0d matrix settings (%0d perspective)",
             sent, 19, persp_sets + 1);
    $display("phases ran with no idling, sender gaps, receiver stalls and both");
    if (fails == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
